@@ hw/rtl/weighted_random_select_assert.svh @@
// Assertion macros for the weighted random select block.
// Expects clk_i and rst_ni in the scope of use.
`ifndef WEIGHTED_RANDOM_SELECT_ASSERT_SVH
`define WEIGHTED_RANDOM_SELECT_ASSERT_SVH

// same-cycle implication
`define WRS_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WRS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/wrs_pkg.sv @@
// Shared types and constants for the weighted random select block.
// No dependencies.
`default_nettype none

package wrs_pkg;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_SELECT = 2'd2;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_SELECT,
    CMD_BAD
  } cmd_e;

  typedef struct packed {
    cmd_e                 op;
    logic [FIELD_W-1:0]   weight;
    logic                 has_weight;
    logic [FIELD_W-1:0]   r1;
    logic [FIELD_W-1:0]   r2;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_st_t;

endpackage

`default_nettype wire

@@ hw/rtl/wrs_front.sv @@
// Input stage: accepts transactions, decodes the mode, pushes commands.
// Depends on wrs_pkg.
`default_nettype none

module wrs_front import wrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [FIELD_W-1:0] weight_i,
  input  logic               has_weight_i,
  input  logic [FIELD_W-1:0] first_random_i,
  input  logic [FIELD_W-1:0] second_random_i,
  input  q_st_t              q_st_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  logic fe_valid_q, fe_valid_d;
  cmd_t fe_cmd_q;
  cmd_t dec_cmd;
  logic accept;

  always_comb begin
    dec_cmd.weight     = weight_i;
    dec_cmd.has_weight = has_weight_i;
    dec_cmd.r1         = first_random_i;
    dec_cmd.r2         = second_random_i;
    unique case (mode_i)
      MODE_CLEAR:  dec_cmd.op = CMD_CLEAR;
      MODE_APPEND: dec_cmd.op = CMD_APPEND;
      MODE_SELECT: dec_cmd.op = CMD_SELECT;
      default:     dec_cmd.op = CMD_BAD;
    endcase
  end

  assign push_o     = fe_valid_q && !q_st_i.full;
  assign in_stall_o = fe_valid_q && q_st_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign fe_valid_d = accept || (fe_valid_q && !push_o);
  assign cmd_o      = fe_cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fe_valid_q <= 1'b0;
    end else begin
      fe_valid_q <= fe_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fe_cmd_q <= dec_cmd;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wrs_queue.sv @@
// Short command queue between front and back.
// Depends on wrs_pkg.
`default_nettype none

module wrs_queue import wrs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cmd_t  cmd_i,
  input  logic  pop_i,
  output cmd_t  cmd_o,
  output q_st_t st_o
);

  cmd_t               slot_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_PTR_W:0]   cnt_q, cnt_d;

  assign st_o.full  = (cnt_q == (Q_PTR_W+1)'(Q_DEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign cmd_o      = slot_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/wrs_back.sv @@
// Execution side: entry table, weighted and uniform walks, result register.
// Depends on wrs_pkg.
`default_nettype none

module wrs_back import wrs_pkg::*; #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_st_t      q_st_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       idle_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] entry_index_o,
  output logic       valid_res_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned SUM_W = WEIGHT_BITS + CNT_W;
  localparam int unsigned CMP_W = SUM_W + FIELD_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WALK1 = 5'b00010,
    ST_PICK  = 5'b00100,
    ST_WALK2 = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [WEIGHT_BITS:0] mem [ENTRIES];
  logic [WEIGHT_BITS:0] rdata_q;
  logic [IDX_W-1:0]     rd_addr, wr_addr;
  logic [WEIGHT_BITS:0] wr_data;
  logic                 wr_en;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic [IDX_W-1:0]   didx_q, didx_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   unw_q, unw_d;
  logic [CNT_W-1:0]   seen_q, seen_d;
  logic [CNT_W-1:0]   pick_q, pick_d;
  logic [FIELD_W-1:0] r1_q, r1_d, r2_q, r2_d;
  logic [IDX_W-1:0]   res_idx_q, res_idx_d;
  logic               res_ok_q, res_ok_d;

  logic               out_valid_q, out_valid_d;
  logic [3:0]         out_idx_q;
  logic               out_ok_q;
  logic               out_load;
  logic               out_free;

  logic                     mark;
  logic                     last;
  logic [CMP_W-1:0]         lhs, rhs;
  logic [CNT_W+FIELD_W-1:0] prod;
  logic [CNT_W-1:0]         pick_raw;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign mark          = rdata_q[WEIGHT_BITS];
  assign last          = (CNT_W'(didx_q) == (count_q - 1'b1));
  assign lhs           = CMP_W'({r1_q, {WEIGHT_BITS{1'b0}}});
  assign rhs           = {sum_q + SUM_W'(rdata_q[WEIGHT_BITS-1:0]), {FIELD_W{1'b0}}};
  assign prod          = CNT_W'(unw_q) * r2_q;
  assign pick_raw      = prod[CNT_W+FIELD_W-1:FIELD_W];
  assign idle_o        = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign entry_index_o = out_idx_q;
  assign valid_res_o   = out_ok_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    didx_d      = didx_q;
    sum_d       = sum_q;
    unw_d       = unw_q;
    seen_d      = seen_q;
    pick_d      = pick_q;
    r1_d        = r1_q;
    r2_d        = r2_q;
    res_idx_d   = res_idx_q;
    res_ok_d    = res_ok_q;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = count_q[IDX_W-1:0];
    wr_data     = {cmd_i.has_weight, WEIGHT_BITS'(cmd_i.weight)};
    pop_o       = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    // keep the read pipeline one entry ahead during the walks
    if ((state_q == ST_WALK1 || state_q == ST_WALK2) && (issue_q < count_q)) begin
      rd_addr = issue_q[IDX_W-1:0];
      didx_d  = issue_q[IDX_W-1:0];
      issue_d = issue_q + 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (!q_st_i.empty) begin
          pop_o     = 1'b1;
          res_idx_d = '0;
          res_ok_d  = 1'b0;
          state_d   = ST_EMIT;
          unique case (cmd_i.op)
            CMD_CLEAR: begin
              count_d  = '0;
              res_ok_d = 1'b1;
            end
            CMD_APPEND: begin
              if (count_q < CNT_W'(ENTRIES)) begin
                wr_en     = 1'b1;
                count_d   = count_q + 1'b1;
                res_idx_d = count_q[IDX_W-1:0];
                res_ok_d  = 1'b1;
              end
            end
            CMD_SELECT: begin
              r1_d  = cmd_i.r1;
              r2_d  = cmd_i.r2;
              sum_d = '0;
              unw_d = '0;
              if (count_q != '0) begin
                rd_addr = '0;
                didx_d  = '0;
                issue_d = CNT_W'(1);
                state_d = ST_WALK1;
              end
            end
            default: begin
              res_ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_WALK1: begin
        if (mark) begin
          sum_d = sum_q + SUM_W'(rdata_q[WEIGHT_BITS-1:0]);
          if (lhs < rhs) begin
            res_idx_d = didx_q;
            res_ok_d  = 1'b1;
            state_d   = ST_EMIT;
          end else if (last) begin
            state_d = ST_PICK;
          end
        end else begin
          unw_d = unw_q + 1'b1;
          if (last) begin
            state_d = ST_PICK;
          end
        end
      end
      ST_PICK: begin
        if (unw_q == '0) begin
          res_idx_d = '0;
          res_ok_d  = 1'b0;
          state_d   = ST_EMIT;
        end else begin
          pick_d  = (pick_raw >= unw_q) ? (unw_q - 1'b1) : pick_raw;
          seen_d  = '0;
          rd_addr = '0;
          didx_d  = '0;
          issue_d = CNT_W'(1);
          state_d = ST_WALK2;
        end
      end
      ST_WALK2: begin
        if (!mark && (seen_q == pick_q)) begin
          res_idx_d = didx_q;
          res_ok_d  = 1'b1;
          state_d   = ST_EMIT;
        end else begin
          if (!mark) begin
            seen_d = seen_q + 1'b1;
          end
          if (last) begin
            res_idx_d = '0;
            res_ok_d  = 1'b0;
            state_d   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q   <= issue_d;
    didx_q    <= didx_d;
    sum_q     <= sum_d;
    unw_q     <= unw_d;
    seen_q    <= seen_d;
    pick_q    <= pick_d;
    r1_q      <= r1_d;
    r2_q      <= r2_d;
    res_idx_q <= res_idx_d;
    res_ok_q  <= res_ok_d;
    if (out_load) begin
      out_idx_q <= 4'(res_idx_q);
      out_ok_q  <= res_ok_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_q <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/weighted_random_select.sv @@
// Clear, append and unknown modes pass the front register, the queue, the back end and its
// result register. Select walks the table one entry per cycle through the table memory
// read port, in up to two passes (weighted, then uniform), with a pick step between them.
// The back end takes one command at a time and pops the next only when idle; a 4-deep
// queue decouples input. Reset empties the table.
// Top level of the weighted random select block; depends on wrs_pkg, wrs_front,
// wrs_queue, wrs_back and the assertion macros.
`default_nettype none

`include "weighted_random_select_assert.svh"

module weighted_random_select import wrs_pkg::*; #(
  parameter int unsigned ENTRIES     = 16,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [FIELD_W-1:0] weight_i,
  input  logic               has_weight_i,
  input  logic [FIELD_W-1:0] first_random_i,
  input  logic [FIELD_W-1:0] second_random_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         entry_index_o,
  output logic               valid_res_o
);

  logic  push, pop, back_idle;
  cmd_t  fe_cmd, q_cmd;
  q_st_t q_st;

  wrs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .weight_i       (weight_i),
    .has_weight_i   (has_weight_i),
    .first_random_i (first_random_i),
    .second_random_i(second_random_i),
    .q_st_i         (q_st),
    .push_o         (push),
    .cmd_o          (fe_cmd)
  );

  wrs_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (fe_cmd),
    .pop_i (pop),
    .cmd_o (q_cmd),
    .st_o  (q_st)
  );

  wrs_back #(
    .ENTRIES    (ENTRIES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_st_i       (q_st),
    .cmd_i        (q_cmd),
    .pop_o        (pop),
    .idle_o       (back_idle),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .entry_index_o(entry_index_o),
    .valid_res_o  (valid_res_o)
  );

  `WRS_ASSERT_IMPLIES(a_no_push_full, push, !q_st.full, "push into full queue")
  `WRS_ASSERT_IMPLIES(a_no_pop_empty, pop, !q_st.empty && back_idle, "bad queue pop")
  `WRS_ASSERT_NEXT(a_pop_busy, pop, !back_idle, "back end idle after pop")
  `WRS_ASSERT_IMPLIES(a_fail_index, out_valid_o && !valid_res_o, entry_index_o == 4'd0,
    "failed result with nonzero index")

endmodule

`default_nettype wire

@@ verif/tb_weighted_random_select.sv @@
// Testbench for weighted_random_select: directed and random clear/append/select/unknown-mode
// traffic checked against a behavioral roulette-wheel predictor, random input gaps and output stalls.
// Depends on wrs_pkg and the weighted_random_select RTL.

module tb_weighted_random_select;
  import wrs_pkg::*;

  localparam int unsigned ENTRIES      = 16;
  localparam int unsigned WEIGHT_BITS  = 16;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CALM_ITEMS   = 50;
  localparam int unsigned TAIL_CYCLES  = 2 * ENTRIES + 12;
  localparam logic [1:0]  MODE_BAD     = 2'(CMD_BAD);

  typedef struct {
    logic [1:0]         mode;
    logic [FIELD_W-1:0] weight;
    logic               has_w;
    logic [FIELD_W-1:0] r1;
    logic [FIELD_W-1:0] r2;
    bit                 drain_first;
  } table_op_t;

  typedef struct packed {
    logic [3:0] idx;
    logic       found;
  } pick_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         mode = MODE_CLEAR;
  logic [FIELD_W-1:0] weight = '0;
  logic               has_weight = 1'b0;
  logic [FIELD_W-1:0] first_random = '0;
  logic [FIELD_W-1:0] second_random = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         entry_index;
  logic               valid_res;

  // predictor copy of the table
  logic [WEIGHT_BITS-1:0] wt_table [ENTRIES];
  bit                     wt_marked [ENTRIES];
  int unsigned            wt_count = 0;

  table_op_t   pending_ops [$];
  pick_t       expected_picks [$];
  table_op_t   cur_op;
  pick_t       want;
  bit          took;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned accepted_cnt = 0;
  int unsigned retired_cnt = 0;
  int unsigned total_ops = 0;
  int unsigned calm_from = 32'hFFFF_FFFF;
  int unsigned mismatches = 0;
  int unsigned n_clear = 0, n_append = 0, n_refused = 0;
  int unsigned n_select = 0, n_by_weight = 0, n_fallback = 0, n_missed = 0;
  logic        calm;

  assign calm = accepted_cnt >= calm_from;

  weighted_random_select #(
    .ENTRIES    (ENTRIES),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .weight_i       (weight),
    .has_weight_i   (has_weight),
    .first_random_i (first_random),
    .second_random_i(second_random),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .entry_index_o  (entry_index),
    .valid_res_o    (valid_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Applies one transaction to the table copy and returns the result it must give.
  function automatic pick_t apply_table_op(table_op_t op);
    pick_t       res;
    logic [63:0] run_sum;
    logic [63:0] lhs;
    logic [63:0] slot;
    int unsigned n_free;
    int unsigned seen;
    res = '0;
    run_sum = '0;
    lhs = 64'(op.r1) << WEIGHT_BITS;
    n_free = 0;
    seen = 0;
    case (op.mode)
      MODE_CLEAR: begin
        n_clear++;
        wt_count = 0;
        res.found = 1'b1;
      end
      MODE_APPEND: begin
        n_append++;
        if (wt_count >= ENTRIES) begin
          n_refused++;
        end else begin
          wt_table[wt_count] = op.weight[WEIGHT_BITS-1:0];
          wt_marked[wt_count] = op.has_w;
          res.idx = 4'(wt_count);
          res.found = 1'b1;
          wt_count++;
        end
      end
      MODE_SELECT: begin
        n_select++;
        for (int i = 0; i < wt_count; i++) begin
          if (!wt_marked[i]) begin
            n_free++;
          end else begin
            run_sum += 64'(wt_table[i]);
            if (lhs < (run_sum << 16)) begin
              n_by_weight++;
              res.idx = 4'(i);
              res.found = 1'b1;
              return res;
            end
          end
        end
        if (n_free != 0) begin
          slot = (64'(n_free) * 64'(op.r2)) >> 16;
          if (slot >= 64'(n_free)) slot = 64'(n_free - 1);
          for (int i = 0; i < wt_count; i++) begin
            if (!wt_marked[i]) begin
              if (64'(seen) == slot) begin
                n_fallback++;
                res.idx = 4'(i);
                res.found = 1'b1;
                return res;
              end
              seen++;
            end
          end
        end
        n_missed++;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic push_op(input logic [1:0] m, input int unsigned w, input bit hw,
                         input int unsigned r1, input int unsigned r2, input bit drain);
    table_op_t op;
    op.mode = m;
    op.weight = w[FIELD_W-1:0];
    op.has_w = hw;
    op.r1 = r1[FIELD_W-1:0];
    op.r2 = r2[FIELD_W-1:0];
    op.drain_first = drain;
    pending_ops.push_back(op);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        expected_picks.push_back(apply_table_op(cur_op));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || took) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0 ||
                     (pending_ops[0].drain_first && (took || accepted_cnt != retired_cnt))) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else begin
          cur_op = pending_ops.pop_front();
          mode <= cur_op.mode;
          weight <= cur_op.weight;
          has_weight <= cur_op.has_w;
          first_random <= cur_op.r1;
          second_random <= cur_op.r2;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // output backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result: index %0d valid %0b",
                                  entry_index, valid_res));
      end else begin
        want = expected_picks.pop_front();
        if (entry_index !== want.idx || valid_res !== want.found)
          report_mismatch($sformatf("result %0d: index %0d want %0d, valid %0b want %0b",
                                    retired_cnt, entry_index, want.idx, valid_res,
                                    want.found));
        retired_cnt <= retired_cnt + 1;
      end
    end
  end

  initial begin
    int unsigned directed_n, phase, share, wmax, n_app, n_sel, gen_fill, gen_sum;
    int unsigned w, r1, r2;
    bit          hw, drain;
    phase = 0;
    gen_fill = 0;
    gen_sum = 0;

    // directed: empty table, unknown mode, full-scale weight, full table, fallback
    push_op(MODE_SELECT, 16'h1234, 1'b1, 0, 0, 1'b0);
    push_op(MODE_BAD, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
    push_op(MODE_APPEND, 16'hFFFF, 1'b1, 0, 0, 1'b0);
    push_op(MODE_SELECT, 0, 1'b0, 16'hFFFE, 16'hFFFF, 1'b0);
    push_op(MODE_SELECT, 0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    push_op(MODE_CLEAR, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 1'b0);
    for (int k = 0; k < ENTRIES; k++)
      push_op(MODE_APPEND, (k == ENTRIES - 1) ? 16'hFFFF : k * k,
              (k % 3 != 1) && (k != ENTRIES - 1), $urandom, $urandom, 1'b0);
    push_op(MODE_APPEND, 16'h5555, 1'b1, 0, 0, 1'b1);
    push_op(MODE_SELECT, 0, 1'b0, 0, 0, 1'b0);
    push_op(MODE_SELECT, 0, 1'b0, 16'hFFFF, 16'hFFFF, 1'b0);
    push_op(MODE_SELECT, 0, 1'b0, 16'hFFFF, 0, 1'b0);
    directed_n = pending_ops.size();

    // random: mostly clear, append to the table, then select from it one to six times
    while (pending_ops.size() < directed_n + RANDOM_ITEMS) begin
      phase++;
      drain = (phase % 10 == 4);
      if ($urandom_range(0, 9) < 7 || gen_fill >= ENTRIES) begin
        push_op(MODE_CLEAR, $urandom, $urandom_range(0, 1), $urandom, $urandom, drain);
        drain = 1'b0;
        gen_fill = 0;
        gen_sum = 0;
      end
      share = $urandom_range(0, 4);
      wmax = ($urandom_range(0, 2) == 0) ? 16'hFFFF : $urandom_range(16, 4095);
      n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 19) : $urandom_range(1, 6);
      repeat (n_app) begin
        if ($urandom_range(0, 15) == 0)
          w = $urandom_range(0, 1) ? 16'hFFFF : 0;
        else
          w = $urandom_range(0, wmax);
        hw = $urandom_range(0, 3) < share;
        push_op(MODE_APPEND, w, hw, $urandom, $urandom, drain);
        drain = 1'b0;
        if (gen_fill < ENTRIES) begin
          gen_fill++;
          if (hw) gen_sum += w;
        end
      end
      n_sel = $urandom_range(1, 6);
      repeat (n_sel) begin
        case ($urandom_range(0, 5))
          0: r1 = $urandom;
          1: r1 = $urandom_range(0, 1) ? 16'hFFFF : 0;
          default: r1 = $urandom_range(0, (gen_sum > 16'hFFFF) ? 16'hFFFF : gen_sum);
        endcase
        r2 = ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom;
        push_op(MODE_SELECT, $urandom, $urandom_range(0, 1), r1, r2, 1'b0);
      end
      if ($urandom_range(0, 7) == 0)
        push_op($urandom_range(0, 1) ? MODE_BAD : MODE_SELECT, $urandom,
                $urandom_range(0, 1), $urandom, $urandom, 1'b0);
    end
    total_ops = pending_ops.size();
    calm_from = total_ops - CALM_ITEMS;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt != total_ops || retired_cnt != accepted_cnt) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d transactions: %0d clears, %0d appends (%0d refused when full), %0d selects",
             total_ops, n_clear, n_append, n_refused, n_select);
    $display("Selects: %0d picked by weight, %0d by uniform fallback, %0d found nothing",
             n_by_weight, n_fallback, n_missed);
    if (mismatches == 0) begin
      $display("weighted_random_select verification clean");
    end else begin
      $display("weighted_random_select verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("weighted_random_select verification failed");
    $finish;
  end

endmodule
